// ===== src/ffha_pkg.sv =====
package ffha_pkg;

   localparam int ADDR_W     = 48;
   localparam int REQ_W      = 21;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int COPY_W     = 20;
   localparam int CFG_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int GRAN_BYTES = 16;
   localparam int GRAN_SHIFT = $clog2(GRAN_BYTES);

   localparam int DEF_ARENA_GRANULES     = 65536;
   localparam int DEF_MIN_SPLIT_GRANULES = 1;

   localparam logic [CFG_W-1:0] GROW_RESET  = CFG_W'(4096);
   localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(65536);

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESIZE  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_OOM      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_ADDR = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_IGNORED  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT      = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic                load;
      logic                g_clear;
      logic                rd_g;
      logic                rd_nx;
      logic                g_step;
      logic                prev_cap;
      logic                take_g;
      logic                grow;
      logic                split;
      logic                head;
      logic                moved_set;
      logic                nx_cap;
      logic                nx_none;
      logic                rel_wr;
      logic                prev_wr;
      logic                absorb;
      logic                reloc_save;
      logic                status_we;
      logic [STATUS_W-1:0] status_val;
      logic                out_load;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             req_zero;
      logic             tgt_zero;
      logic             g_lt_brk;
      logic             nx_lt_brk;
      logic             fit;
      logic             addr_match;
      logic             rd_used;
      logic             grow_fail;
      logic             shrink_ok;
      logic             absorb_ok;
      logic             prev_free;
   } sts_type;

endpackage

// ===== src/ffha_ram.sv =====
module ffha_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ffha_dp.sv =====
module ffha_dp import ffha_pkg::*; #(
   parameter int ARENA_GRANULES     = DEF_ARENA_GRANULES,
   parameter int MIN_SPLIT_GRANULES = DEF_MIN_SPLIT_GRANULES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   output sts_type              sts,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [REQ_W-1:0]     req_request_bytes,
   input  logic [ADDR_W-1:0]    req_target_address,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data,
   output logic [ADDR_W-1:0]    rsp_result_address,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_moved,
   output logic [ADDR_W-1:0]    rsp_old_address,
   output logic [COPY_W-1:0]    rsp_copy_bytes
);

   localparam int AW  = $clog2(ARENA_GRANULES);
   localparam int GW  = AW + 1;
   localparam int HW  = AW + 1;
   localparam int PW  = REQ_W + 1 - GRAN_SHIFT;
   localparam int MW0 = (GW > PW) ? GW : PW;
   localparam int MW  = (MW0 > CFG_W) ? MW0 : CFG_W;
   localparam int CW  = MW + 2;
   localparam logic [CW-1:0] ARENA_C = CW'(ARENA_GRANULES);
   localparam logic [CW-1:0] MIN_C   = CW'(MIN_SPLIT_GRANULES);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   // request
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [PW-1:0]       p_ff, p_in;
   logic                req_zero_ff, req_zero_in;
   logic [ADDR_W-1:0]   tgt_ff, tgt_in;
   // walk
   logic [GW-1:0]       g_ff, g_in;
   logic                has_prev_ff, has_prev_in;
   logic [GW-1:0]       prev_ff, prev_in;
   logic [AW-1:0]       prev_size_ff, prev_size_in;
   logic                prev_used_ff, prev_used_in;
   logic [GW-1:0]       cur_ff, cur_in;
   logic [AW-1:0]       cur_size_ff, cur_size_in;
   logic                nx_ok_ff, nx_ok_in;
   logic [AW-1:0]       nx_size_ff, nx_size_in;
   logic [GW-1:0]       brk_ff, brk_in;
   // configuration
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [CFG_W-1:0]    grow_ff, grow_in;
   logic [CFG_W-1:0]    limit_ff, limit_in;
   // result
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                moved_ff, moved_in;
   logic [ADDR_W-1:0]   old_ff, old_in;
   logic [COPY_W-1:0]   copy_ff, copy_in;
   logic [COPY_W-1:0]   copy_tmp_ff, copy_tmp_in;
   // output register
   logic [ADDR_W-1:0]   o_addr_ff, o_addr_in;
   logic [STATUS_W-1:0] o_status_ff, o_status_in;
   logic                o_moved_ff, o_moved_in;
   logic [ADDR_W-1:0]   o_old_ff, o_old_in;
   logic [COPY_W-1:0]   o_copy_ff, o_copy_in;

   // header store port
   logic            rd_en, wr_en;
   logic [AW-1:0]   rd_addr, wr_addr;
   logic [HW-1:0]   rd_data, wr_data;
   logic [AW-1:0]   rd_size;
   logic            rd_used;

   // arithmetic
   logic [REQ_W:0]    rq_sum;
   logic [CW-1:0]     p_ext, rd_size_ext, cur_size_ext, brk_ext;
   logic [CW-1:0]     g_step_val, nx_val, chunk, chunk_m1, lim, brk_sum;
   logic [CW-1:0]     tail_addr, tail_size, nx_add, merged, absorb_size, prev_merged;
   logic              split_ok;
   logic [ADDR_W-1:0] pay_g, pay_cur, copy_wide;

   ffha_ram #(.WIDTH(HW), .DEPTH(ARENA_GRANULES)) u_hdr (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_size = rd_data[AW-1:0];
   assign rd_used = rd_data[AW];

   always_comb begin
      rq_sum       = {1'b0, req_request_bytes} + (REQ_W+1)'(GRAN_BYTES - 1);
      p_ext        = CW'(p_ff);
      rd_size_ext  = CW'(rd_size);
      cur_size_ext = CW'(cur_size_ff);
      brk_ext      = CW'(brk_ff);
      g_step_val   = CW'(g_ff) + ONE_C + rd_size_ext;
      nx_val       = CW'(cur_ff) + ONE_C + cur_size_ext;
      chunk        = (p_ext + ONE_C < CW'(grow_ff)) ? CW'(grow_ff) : p_ext + ONE_C;
      chunk_m1     = chunk - ONE_C;
      lim          = (CW'(limit_ff) < ARENA_C) ? CW'(limit_ff) : ARENA_C;
      brk_sum      = brk_ext + chunk;
      split_ok     = cur_size_ext >= p_ext + ONE_C + MIN_C;
      tail_addr    = CW'(cur_ff) + ONE_C + p_ext;
      tail_size    = cur_size_ext - p_ext - ONE_C;
      nx_add       = nx_ok_ff ? ONE_C + CW'(nx_size_ff) : '0;
      merged       = cur_size_ext + nx_add;
      absorb_size  = cur_size_ext + ONE_C + CW'(nx_size_ff);
      prev_merged  = CW'(prev_size_ff) + ONE_C + cur_size_ext;
      pay_g        = base_ff + ((ADDR_W'(g_ff) + ADDR_W'(1)) << GRAN_SHIFT);
      pay_cur      = base_ff + ((ADDR_W'(cur_ff) + ADDR_W'(1)) << GRAN_SHIFT);
      copy_wide    = ADDR_W'(cur_size_ff) << GRAN_SHIFT;
   end

   // status to controller
   always_comb begin
      sts.cmd        = cmd_ff;
      sts.req_zero   = req_zero_ff;
      sts.tgt_zero   = tgt_ff == '0;
      sts.g_lt_brk   = g_ff < brk_ff;
      sts.nx_lt_brk  = nx_val < brk_ext;
      sts.fit        = !rd_used && (rd_size_ext >= p_ext);
      sts.addr_match = pay_g == tgt_ff;
      sts.rd_used    = rd_used;
      sts.grow_fail  = brk_sum > lim;
      sts.shrink_ok  = cur_size_ext >= p_ext;
      sts.absorb_ok  = nx_ok_ff && (absorb_size >= p_ext);
      sts.prev_free  = has_prev_ff && !prev_used_ff;
   end

   // header store access
   always_comb begin
      rd_en   = ctl.rd_g | ctl.rd_nx;
      rd_addr = ctl.rd_nx ? nx_val[AW-1:0] : g_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = cur_ff[AW-1:0];
      wr_data = {1'b1, cur_size_ff};
      if (ctl.grow) begin
         wr_en   = 1'b1;
         wr_addr = brk_ff[AW-1:0];
         wr_data = {1'b0, chunk_m1[AW-1:0]};
      end else if (ctl.split) begin
         wr_en   = split_ok;
         wr_addr = tail_addr[AW-1:0];
         wr_data = {1'b0, tail_size[AW-1:0]};
      end else if (ctl.head) begin
         wr_en   = 1'b1;
      end else if (ctl.rel_wr) begin
         wr_en   = 1'b1;
         wr_data = {1'b0, merged[AW-1:0]};
      end else if (ctl.prev_wr) begin
         wr_en   = 1'b1;
         wr_addr = prev_ff[AW-1:0];
         wr_data = {1'b0, prev_merged[AW-1:0]};
      end else if (ctl.absorb) begin
         wr_en   = 1'b1;
         wr_data = {1'b1, absorb_size[AW-1:0]};
      end
   end

   always_comb begin
      cmd_in       = cmd_ff;
      p_in         = p_ff;
      req_zero_in  = req_zero_ff;
      tgt_in       = tgt_ff;
      g_in         = g_ff;
      has_prev_in  = has_prev_ff;
      prev_in      = prev_ff;
      prev_size_in = prev_size_ff;
      prev_used_in = prev_used_ff;
      cur_in       = cur_ff;
      cur_size_in  = cur_size_ff;
      nx_ok_in     = nx_ok_ff;
      nx_size_in   = nx_size_ff;
      brk_in       = brk_ff;
      base_in      = base_ff;
      grow_in      = grow_ff;
      limit_in     = limit_ff;
      res_addr_in  = res_addr_ff;
      status_in    = status_ff;
      moved_in     = moved_ff;
      old_in       = old_ff;
      copy_in      = copy_ff;
      copy_tmp_in  = copy_tmp_ff;
      o_addr_in    = o_addr_ff;
      o_status_in  = o_status_ff;
      o_moved_in   = o_moved_ff;
      o_old_in     = o_old_ff;
      o_copy_in    = o_copy_ff;

      if (ctl.load) begin
         cmd_in      = req_command;
         p_in        = rq_sum[REQ_W:GRAN_SHIFT];
         req_zero_in = req_request_bytes == '0;
         tgt_in      = req_target_address;
         res_addr_in = '0;
         status_in   = STAT_OK;
         moved_in    = 1'b0;
         old_in      = '0;
         copy_in     = '0;
      end
      if (ctl.g_clear) begin
         g_in        = '0;
         has_prev_in = 1'b0;
      end
      if (ctl.g_step) begin
         g_in = g_step_val[GW-1:0];
      end
      if (ctl.prev_cap) begin
         has_prev_in  = 1'b1;
         prev_in      = g_ff;
         prev_size_in = rd_size;
         prev_used_in = rd_used;
      end
      if (ctl.take_g) begin
         cur_in      = g_ff;
         cur_size_in = rd_size;
      end
      if (ctl.grow) begin
         cur_in      = brk_ff;
         cur_size_in = chunk_m1[AW-1:0];
         brk_in      = brk_sum[GW-1:0];
      end
      if (ctl.split && split_ok) begin
         cur_size_in = p_ext[AW-1:0];
      end
      if (ctl.head) begin
         res_addr_in = pay_cur;
      end
      if (ctl.moved_set) begin
         moved_in = 1'b1;
         old_in   = tgt_ff;
         copy_in  = copy_tmp_ff;
      end
      if (ctl.nx_cap) begin
         nx_ok_in   = !rd_used;
         nx_size_in = rd_size;
      end
      if (ctl.nx_none) begin
         nx_ok_in = 1'b0;
      end
      if (ctl.rel_wr) begin
         cur_size_in = merged[AW-1:0];
      end
      if (ctl.absorb) begin
         res_addr_in = tgt_ff;
      end
      if (ctl.reloc_save) begin
         copy_tmp_in = copy_wide[COPY_W-1:0];
      end
      if (ctl.status_we) begin
         status_in = ctl.status_val;
      end
      if (ctl.out_load) begin
         o_addr_in   = res_addr_ff;
         o_status_in = status_ff;
         o_moved_in  = moved_ff;
         o_old_in    = old_ff;
         o_copy_in   = copy_ff;
      end
      if (csr_we) begin
         case (csr_index)
            CSR_ARENA_BASE: base_in  = csr_data;
            CSR_GROW:       grow_in  = csr_data[CFG_W-1:0];
            CSR_LIMIT:      limit_in = csr_data[CFG_W-1:0];
            default:        base_in  = base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brk_ff   <= '0;
         base_ff  <= '0;
         grow_ff  <= GROW_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         brk_ff   <= brk_in;
         base_ff  <= base_in;
         grow_ff  <= grow_in;
         limit_ff <= limit_in;
      end
      cmd_ff       <= cmd_in;
      p_ff         <= p_in;
      req_zero_ff  <= req_zero_in;
      tgt_ff       <= tgt_in;
      g_ff         <= g_in;
      has_prev_ff  <= has_prev_in;
      prev_ff      <= prev_in;
      prev_size_ff <= prev_size_in;
      prev_used_ff <= prev_used_in;
      cur_ff       <= cur_in;
      cur_size_ff  <= cur_size_in;
      nx_ok_ff     <= nx_ok_in;
      nx_size_ff   <= nx_size_in;
      res_addr_ff  <= res_addr_in;
      status_ff    <= status_in;
      moved_ff     <= moved_in;
      old_ff       <= old_in;
      copy_ff      <= copy_in;
      copy_tmp_ff  <= copy_tmp_in;
      o_addr_ff    <= o_addr_in;
      o_status_ff  <= o_status_in;
      o_moved_ff   <= o_moved_in;
      o_old_ff     <= o_old_in;
      o_copy_ff    <= o_copy_in;
   end

   assign rsp_result_address = o_addr_ff;
   assign rsp_status         = o_status_ff;
   assign rsp_moved          = o_moved_ff;
   assign rsp_old_address    = o_old_ff;
   assign rsp_copy_bytes     = o_copy_ff;

endmodule

// ===== src/ffha_ctrl.sv =====
module ffha_ctrl import ffha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_AW_RD, ST_AW_CHK, ST_GROW, ST_SPLIT, ST_HEAD,
      ST_LW_RD, ST_LW_CHK, ST_NX_RD, ST_NX_CHK, ST_DECIDE, ST_PREV, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      mode_rsz_ff, mode_rsz_in;   // locate walk on behalf of resize
   logic      reloc_ff, reloc_in;         // allocating on behalf of a moving resize
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      mode_rsz_in  = mode_rsz_ff;
      reloc_in     = reloc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ctl.g_clear = 1'b1;
            reloc_in    = 1'b0;
            mode_rsz_in = 1'b0;
            case (sts.cmd)
               CMD_ALLOC: begin
                  if (sts.req_zero) begin
                     ctl.status_we  = 1'b1;
                     ctl.status_val = STAT_OOM;
                     state_in       = ST_DONE;
                  end else begin
                     state_in = ST_AW_RD;
                  end
               end
               CMD_RELEASE: begin
                  state_in = sts.tgt_zero ? ST_DONE : ST_LW_RD;
               end
               CMD_RESIZE: begin
                  if (sts.tgt_zero && sts.req_zero) begin
                     ctl.status_we  = 1'b1;
                     ctl.status_val = STAT_OOM;
                     state_in       = ST_DONE;
                  end else if (sts.tgt_zero) begin
                     state_in = ST_AW_RD;
                  end else begin
                     mode_rsz_in = !sts.req_zero;
                     state_in    = ST_LW_RD;
                  end
               end
               default: begin
                  ctl.status_we  = 1'b1;
                  ctl.status_val = STAT_BAD_ADDR;
                  state_in       = ST_DONE;
               end
            endcase
         end
         ST_AW_RD: begin
            if (sts.g_lt_brk) begin
               ctl.rd_g = 1'b1;
               state_in = ST_AW_CHK;
            end else begin
               state_in = ST_GROW;
            end
         end
         ST_AW_CHK: begin
            if (sts.fit) begin
               ctl.take_g = 1'b1;
               state_in   = ST_SPLIT;
            end else begin
               ctl.g_step = 1'b1;
               state_in   = ST_AW_RD;
            end
         end
         ST_GROW: begin
            if (sts.grow_fail) begin
               ctl.status_we  = 1'b1;
               ctl.status_val = STAT_OOM;
               state_in       = ST_DONE;
            end else begin
               ctl.grow = 1'b1;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            ctl.split = 1'b1;
            state_in  = ST_HEAD;
         end
         ST_HEAD: begin
            ctl.head = 1'b1;
            if (reloc_ff) begin
               // new block granted: free the old one by a fresh walk
               ctl.moved_set = 1'b1;
               ctl.g_clear   = 1'b1;
               reloc_in      = 1'b0;
               mode_rsz_in   = 1'b0;
               state_in      = ST_LW_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LW_RD: begin
            if (sts.g_lt_brk) begin
               ctl.rd_g = 1'b1;
               state_in = ST_LW_CHK;
            end else begin
               ctl.status_we  = 1'b1;
               ctl.status_val = mode_rsz_ff ? STAT_BAD_ADDR : STAT_IGNORED;
               state_in       = ST_DONE;
            end
         end
         ST_LW_CHK: begin
            if (sts.addr_match && sts.rd_used) begin
               ctl.take_g = 1'b1;
               state_in   = ST_NX_RD;
            end else if (sts.addr_match) begin
               ctl.status_we  = 1'b1;
               ctl.status_val = mode_rsz_ff ? STAT_BAD_ADDR : STAT_IGNORED;
               state_in       = ST_DONE;
            end else begin
               ctl.g_step   = 1'b1;
               ctl.prev_cap = 1'b1;
               state_in     = ST_LW_RD;
            end
         end
         ST_NX_RD: begin
            if (sts.nx_lt_brk) begin
               ctl.rd_nx = 1'b1;
               state_in  = ST_NX_CHK;
            end else begin
               ctl.nx_none = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_NX_CHK: begin
            ctl.nx_cap = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!mode_rsz_ff) begin
               ctl.rel_wr = 1'b1;
               state_in   = sts.prev_free ? ST_PREV : ST_DONE;
            end else if (sts.shrink_ok) begin
               state_in = ST_SPLIT;
            end else if (sts.absorb_ok) begin
               ctl.absorb = 1'b1;
               state_in   = ST_DONE;
            end else begin
               ctl.reloc_save = 1'b1;
               ctl.g_clear    = 1'b1;
               reloc_in       = 1'b1;
               state_in       = ST_AW_RD;
            end
         end
         ST_PREV: begin
            ctl.prev_wr = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               ctl.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_rsz_ff  <= 1'b0;
         reloc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_rsz_ff  <= mode_rsz_in;
         reloc_ff     <= reloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.grow, ctl.split, ctl.head, ctl.rel_wr, ctl.prev_wr, ctl.absorb}))
      else $error("two header writes in one cycle");

   a_one_read: assert property (@(posedge clock) disable iff (reset)
      !(ctl.rd_g && ctl.rd_nx))
      else $error("two header reads in one cycle");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded");

endmodule

// ===== src/first_fit_heap_allocator_unit.sv =====
// Sequence: an allocate walks the block headers for a first fit and grows the
//    break when none fits; a release merges its block with free neighbours.
// Throughput: one request at a time, set by the header store walk;
//    the next request is taken while the previous result still waits.
// Reset (synchronous): arena emptied (break 0), registers to defaults; the
//    header store is not cleared, only written headers are ever read.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
   parameter int ARENA_GRANULES     = DEF_ARENA_GRANULES,
   parameter int MIN_SPLIT_GRANULES = DEF_MIN_SPLIT_GRANULES
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [REQ_W-1:0]     req_request_bytes,
   input  logic [ADDR_W-1:0]    req_target_address,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_W-1:0]    rsp_result_address,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_moved,
   output logic [ADDR_W-1:0]    rsp_old_address,
   output logic [COPY_W-1:0]    rsp_copy_bytes,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data
);

   ctl_type ctl;
   sts_type sts;

   // register writes are always accepted
   assign csr_ready = 1'b1;

   // sequencer: walks, grow, split, merge decisions
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // header store, break, walk pointers and result registers
   ffha_dp #(
      .ARENA_GRANULES     (ARENA_GRANULES),
      .MIN_SPLIT_GRANULES (MIN_SPLIT_GRANULES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_command        (req_command),
      .req_request_bytes  (req_request_bytes),
      .req_target_address (req_target_address),
      .csr_we             (csr_valid & csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .rsp_moved          (rsp_moved),
      .rsp_old_address    (rsp_old_address),
      .rsp_copy_bytes     (rsp_copy_bytes)
   );

endmodule

// ===== tb/first_fit_heap_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit_tb;
   import ffha_pkg::*;

   localparam int NGRAN = DEF_ARENA_GRANULES;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [REQ_W-1:0]  bytes;
      logic [ADDR_W-1:0] target;
   } heap_req_t;

   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [STATUS_W-1:0] status;
      logic                moved;
      logic [ADDR_W-1:0]   old_addr;
      logic [COPY_W-1:0]   copy;
   } heap_rsp_t;

   // directed row: request plus an optional hand-typed result
   typedef struct packed {
      heap_req_t req;
      logic      fixed;
      heap_rsp_t rsp;
   } heap_row_t;

   logic                 clock, reset;
   logic                 req_valid, req_stall;
   logic [CMD_W-1:0]     req_command;
   logic [REQ_W-1:0]     req_request_bytes;
   logic [ADDR_W-1:0]    req_target_address;
   logic                 rsp_valid, rsp_stall;
   logic [ADDR_W-1:0]    rsp_result_address;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_moved;
   logic [ADDR_W-1:0]    rsp_old_address;
   logic [COPY_W-1:0]    rsp_copy_bytes;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_data;

   first_fit_heap_allocator_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow heap state
   logic [16:0]       hdr_size [NGRAN];
   logic              hdr_used [NGRAN];
   int unsigned       brk;
   logic [ADDR_W-1:0] base_q;
   int unsigned       grow_q, limit_q;

   heap_rsp_t expected_q[$];
   logic [ADDR_W-1:0] live_addrs[$];   // addresses currently granted
   int   fails;
   int   n_rsp;
   bit   quiet_rsp;      // no result stall in the closing stretch
   int   n_moved, n_oom, n_ignored;

   function automatic logic [ADDR_W-1:0] payload_of(int unsigned g);
      return base_q + ADDR_W'((g + 1) * GRAN_BYTES);
   endfunction

   function automatic bit find_block(logic [ADDR_W-1:0] a, output int unsigned at,
                                     output int unsigned prv, output bit has_prv);
      int unsigned g;
      g = 0;
      has_prv = 0;
      at = 0;
      prv = 0;
      while (g < brk) begin
         if (payload_of(g) == a) begin
            at = g;
            return 1;
         end
         prv = g;
         has_prv = 1;
         g += 1 + hdr_size[g];
      end
      return 0;
   endfunction

   function automatic void carve_tail(int unsigned g, int unsigned p);
      int unsigned s;
      s = hdr_size[g];
      if (s >= p + 1 + DEF_MIN_SPLIT_GRANULES) begin
         hdr_size[g+1+p] = 17'(s - p - 1);
         hdr_used[g+1+p] = 0;
         hdr_size[g] = 17'(p);
      end
   endfunction

   function automatic logic [STATUS_W-1:0] heap_grab(int unsigned bytes,
                                                     output logic [ADDR_W-1:0] a);
      int unsigned p, g, chunk, lim;
      bit hit;
      a = '0;
      hit = 0;
      g = 0;
      if (bytes == 0) return STAT_OOM;
      p = (bytes + GRAN_BYTES - 1) / GRAN_BYTES;
      while (g < brk) begin
         if (!hdr_used[g] && hdr_size[g] >= p) begin
            hit = 1;
            break;
         end
         g += 1 + hdr_size[g];
      end
      if (!hit) begin
         chunk = (p + 1 < grow_q) ? grow_q : p + 1;
         lim = (limit_q < NGRAN) ? limit_q : NGRAN;
         if (brk + chunk > lim) return STAT_OOM;
         g = brk;
         hdr_size[g] = 17'(chunk - 1);
         hdr_used[g] = 0;
         brk += chunk;
      end
      carve_tail(g, p);
      hdr_used[g] = 1;
      a = payload_of(g);
      return STAT_OK;
   endfunction

   function automatic logic [STATUS_W-1:0] heap_free(logic [ADDR_W-1:0] a);
      int unsigned g, prv, s, nx;
      bit has_prv;
      if (!find_block(a, g, prv, has_prv) || !hdr_used[g]) return STAT_IGNORED;
      s = hdr_size[g];
      nx = g + 1 + s;
      if (nx < brk && !hdr_used[nx]) s += 1 + hdr_size[nx];
      hdr_size[g] = 17'(s);
      hdr_used[g] = 0;
      if (has_prv && !hdr_used[prv]) hdr_size[prv] = 17'(hdr_size[prv] + 1 + s);
      return STAT_OK;
   endfunction

   function automatic void forget_addr(logic [ADDR_W-1:0] a);
      foreach (live_addrs[i])
         if (live_addrs[i] == a) begin
            live_addrs.delete(i);
            return;
         end
   endfunction

   // work out the response to one request and update the shadow heap
   function automatic heap_rsp_t heap_predict(heap_req_t r);
      heap_rsp_t o;
      int unsigned g, prv, p, s, nx;
      bit has_prv;
      o = '0;
      case (r.cmd)
         CMD_ALLOC: o.status = heap_grab(r.bytes, o.addr);
         CMD_RELEASE: begin
            if (r.target != 0) o.status = heap_free(r.target);
         end
         CMD_RESIZE: begin
            if (r.target == 0) o.status = heap_grab(r.bytes, o.addr);
            else if (r.bytes == 0) o.status = heap_free(r.target);
            else if (!find_block(r.target, g, prv, has_prv) || !hdr_used[g])
               o.status = STAT_BAD_ADDR;
            else begin
               p = (r.bytes + GRAN_BYTES - 1) / GRAN_BYTES;
               s = hdr_size[g];
               nx = g + 1 + s;
               if (s >= p) begin
                  carve_tail(g, p);
                  o.addr = r.target;
               end else if (nx < brk && !hdr_used[nx] && s + 1 + hdr_size[nx] >= p) begin
                  // absorbed block is kept whole
                  hdr_size[g] = 17'(s + 1 + hdr_size[nx]);
                  o.addr = r.target;
               end else begin
                  o.status = heap_grab(r.bytes, o.addr);
                  if (o.status == STAT_OK) begin
                     o.moved = 1;
                     o.old_addr = r.target;
                     o.copy = COPY_W'(s * GRAN_BYTES);
                     void'(heap_free(r.target));
                  end
               end
            end
         end
         default: o.status = STAT_BAD_ADDR;
      endcase
      return o;
   endfunction

   // bookkeeping of granted addresses, used to aim the random requests
   function automatic void track(heap_req_t r, heap_rsp_t o);
      if (o.status != STAT_OK) return;
      if (r.cmd == CMD_RELEASE || (r.cmd == CMD_RESIZE && r.target != 0 && r.bytes == 0))
         forget_addr(r.target);
      else if (o.moved) begin
         forget_addr(o.old_addr);
         live_addrs.push_back(o.addr);
      end else if (o.addr != 0 && !(r.cmd == CMD_RESIZE && r.target != 0))
         live_addrs.push_back(o.addr);
      if (o.moved) n_moved++;
   endfunction

   task automatic idle_burst();
      repeat ($urandom_range(1, 9)) @(negedge clock);
   endtask

   // one transfer on the request channel; valid stays up afterwards until
   // the next transfer replaces it or the caller drops it
   task automatic send_req(heap_req_t r, bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         idle_burst();
      end
      req_valid          <= 1'b1;
      req_command        <= r.cmd;
      req_request_bytes  <= r.bytes;
      req_target_address <= r.target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_ARENA_BASE: base_q  = val;
         CSR_GROW:       grow_q  = val[CFG_W-1:0];
         CSR_LIMIT:      limit_q = val[CFG_W-1:0];
         default: ;
      endcase
   endtask

   // let every outstanding result drain, then a latency margin
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // checker: compares each result transfer with the oldest expectation
   always @(posedge clock) begin
      heap_rsp_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected");
            fails++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_result_address !== e.addr) begin
               $error("result_address exp %h got %h", e.addr, rsp_result_address);
               fails++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               fails++;
            end
            if (rsp_moved !== e.moved) begin
               $error("moved exp %0d got %0d", e.moved, rsp_moved);
               fails++;
            end
            if (rsp_old_address !== e.old_addr) begin
               $error("old_address exp %h got %h", e.old_addr, rsp_old_address);
               fails++;
            end
            if (rsp_copy_bytes !== e.copy) begin
               $error("copy_bytes exp %h got %h", e.copy, rsp_copy_bytes);
               fails++;
            end
         end
      end
   end

   // result-side stall bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet_rsp && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // queue the expectation for a request and push it through the port
   task automatic issue(heap_req_t r, bit gaps);
      heap_rsp_t o;
      o = heap_predict(r);
      track(r, o);
      if (o.status == STAT_OOM) n_oom++;
      if (o.status == STAT_IGNORED) n_ignored++;
      expected_q.push_back(o);
      send_req(r, gaps);
   endtask

   function automatic heap_req_t rand_req(int mode);
      heap_req_t r;
      int unsigned k;
      r.cmd = CMD_W'($urandom_range(0, 2));
      k = $urandom_range(0, 99);
      // mostly small sizes, a few large ones, a few zero
      if (k < 80) r.bytes = REQ_W'($urandom_range(1, 200));
      else if (k < 95) r.bytes = REQ_W'($urandom_range(1, 1 << 14));
      else if (k < 98) r.bytes = REQ_W'($urandom_range(0, 1 << 20));
      else r.bytes = '0;
      k = $urandom_range(0, 99);
      if (live_addrs.size() != 0 && k < 75)
         r.target = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
      else if (k < 85) r.target = '0;
      else if (k < 92) r.target = payload_of($urandom_range(0, 64));
      else r.target = ADDR_W'({$urandom, $urandom});
      if (mode == 1 && $urandom_range(0, 49) == 0) r.cmd = 2'd3;
      return r;
   endfunction

   localparam int N_ROWS = 18;
   localparam logic [ADDR_W-1:0] MAXA = '1;

   heap_row_t rows [N_ROWS];

   initial begin
      fails = 0;
      n_rsp = 0;
      n_moved = 0;
      n_oom = 0;
      n_ignored = 0;
      quiet_rsp = 0;
      reset = 1'b1;
      clock = 1'b0;
      req_valid = 1'b0;
      req_command = CMD_ALLOC;
      req_request_bytes = '0;
      req_target_address = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ARENA_BASE;
      csr_data = '0;
      brk = 0;
      base_q = '0;
      grow_q = GROW_RESET;
      limit_q = LIMIT_RESET;
      for (int i = 0; i < NGRAN; i++) begin
         hdr_size[i] = '0;
         hdr_used[i] = 0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows; fixed ones are readable straight from the rules, the
      // rest are worked out by the predictor. Defaults: base 0, grow 4096.
      rows = '{
         '{'{CMD_ALLOC,   21'd0,       48'd0},    1, '{48'd0,  STAT_OOM,      1'b0, 48'd0, 20'd0}},
         '{'{CMD_RELEASE, 21'd0,       48'd0},    1, '{48'd0,  STAT_OK,       1'b0, 48'd0, 20'd0}},
         '{'{CMD_RELEASE, 21'd0,       48'd16},   1, '{48'd0,  STAT_IGNORED,  1'b0, 48'd0, 20'd0}},
         '{'{CMD_RESIZE,  21'd8,       MAXA},     1, '{48'd0,  STAT_BAD_ADDR, 1'b0, 48'd0, 20'd0}},
         '{'{2'd3,        21'h1FFFFF,  MAXA},     1, '{48'd0,  STAT_BAD_ADDR, 1'b0, 48'd0, 20'd0}},
         '{'{CMD_ALLOC,   21'd1,       48'd0},    1, '{48'd16, STAT_OK,       1'b0, 48'd0, 20'd0}},
         '{'{CMD_ALLOC,   21'd1048576, 48'd0},    1, '{48'd0,  STAT_OOM,      1'b0, 48'd0, 20'd0}},
         '{'{CMD_ALLOC,   21'd40,      48'd0},    0, '0},
         '{'{CMD_ALLOC,   21'd17,      48'd0},    0, '0},
         '{'{CMD_RESIZE,  21'd16,      48'd48},   0, '0},   // shrink in place
         '{'{CMD_RELEASE, 21'd0,       48'd16},   0, '0},
         '{'{CMD_RELEASE, 21'd0,       48'd16},   0, '0},   // double free
         '{'{CMD_RESIZE,  21'd100,     48'd48},   0, '0},   // absorb or move
         '{'{CMD_RESIZE,  21'd5000,    48'd48},   0, '0},   // target already moved away: bad address
         '{'{CMD_RESIZE,  21'd0,       48'd0},    0, '0},
         '{'{CMD_RESIZE,  21'd64,      48'd0},    0, '0},
         '{'{CMD_RESIZE,  21'd0,       48'd16},   0, '0},
         '{'{CMD_ALLOC,   21'd65535,   48'd0},    0, '0}
      };
      foreach (rows[i]) begin
         heap_rsp_t o;
         o = heap_predict(rows[i].req);
         track(rows[i].req, o);
         expected_q.push_back(rows[i].fixed ? rows[i].rsp : o);
         send_req(rows[i].req, 1);
      end
      drain();

      // random phases over several register settings, extremes included;
      // reset clears the break, but no phase resets the unit: phases 3 and 4
      // write a fresh base while the arena still holds blocks
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               csr_write(CSR_GROW, ADDR_W'(1));
               csr_write(CSR_LIMIT, ADDR_W'(65536));
            end
            1: begin
               csr_write(CSR_GROW, ADDR_W'(65536));
               csr_write(CSR_LIMIT, ADDR_W'(1));
            end
            2: begin
               csr_write(CSR_GROW, ADDR_W'($urandom_range(1, 300)));
               csr_write(CSR_LIMIT, ADDR_W'($urandom_range(200, 4000)));
            end
            3: csr_write(CSR_ARENA_BASE, MAXA - 48'd40);   // payloads wrap past 2^48
            default: begin
               csr_write(CSR_ARENA_BASE, ADDR_W'({$urandom, $urandom}));
               csr_write(CSR_GROW, ADDR_W'($urandom_range(1, 64)));
               csr_write(CSR_LIMIT, ADDR_W'(65536));
            end
         endcase
         // base changes move every payload; drop stale addresses
         if (ph >= 3) live_addrs.delete();
         for (int n = 0; n < 170; n++) begin
            if (ph == 4 && n >= 120) quiet_rsp = 1;
            issue(rand_req(1), !(ph == 4 && n >= 120));
            // wait for a full drain once per phase
            if (n == 60) begin
               req_valid <= 1'b0;
               while (expected_q.size() != 0) @(negedge clock);
            end
         end
         drain();
      end

      $display("run: %0d results, %0d relocations, %0d out-of-memory, %0d ignored frees",
               n_rsp, n_moved, n_oom, n_ignored);
      $display("covered directed edge cases and five register settings incl. extremes");
      if (fails == 0) $display("PASS first_fit_heap_allocator_unit");
      else $display("FAIL first_fit_heap_allocator_unit");
      $finish;
   end

   initial begin
      #20000000;
      $display("FAIL first_fit_heap_allocator_unit");
      $finish;
   end

endmodule
